// ===== hw/rtl/bmp_stream_pixel_decoder_top_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef BMP_STREAM_PIXEL_DECODER_TOP_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bmpd_pkg.sv =====
`default_nettype none

package bmpd_pkg;

  // Largest image width or height that is accepted.
  localparam int MAX_DIM = 8192;
  // Width that holds a dimension up to MAX_DIM inclusive.
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  // Width that holds a padded row length in bytes.
  localparam int ROW_W = $clog2(4 * MAX_DIM + 4);

  localparam int SURF_W  = 14;
  localparam int POS_W   = 13;
  localparam int COLOR_W = 32;
  localparam int STAT_W  = 3;

  // Result queue depth and pointer width.
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);

  // Configuration register indexes.
  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;
  localparam logic [SURF_W-1:0] SURFACE_WIDTH_RESET  = 14'd640;
  localparam logic [SURF_W-1:0] SURFACE_HEIGHT_RESET = 14'd480;

  // Result kinds.
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // End-of-file status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_SHORT_HDR = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_GEOM  = 3'd4;
  localparam logic [STAT_W-1:0] ST_TRUNCATED = 3'd5;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] color;
    logic [STAT_W-1:0]  status;
    logic               last_of_run;
  } res_t;

  // Up to two results produced by one byte: a pixel write, then a status.
  typedef struct packed {
    logic pix_valid;
    res_t pix;
    logic st_valid;
    res_t st;
  } core_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmpd_res_fifo.sv =====
`default_nettype none
`include "bmp_stream_pixel_decoder_top_macros.svh"

module bmpd_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bmpd_pkg::core_out_t push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bmpd_pkg::res_t         head
);
  import bmpd_pkg::*;

  res_t             mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [1:0]       push_n;
  logic             pop;

  assign push_n    = 2'(push.pix_valid) + 2'(push.st_valid);
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  // The core may push two results per beat, so keep two slots free.
  assign room      = (count <= (PTR_W + 1)'(RES_DEPTH - 2));
  assign head      = mem[rd_ptr];

  // Result storage: the pixel write goes first, the status behind it.
  always_ff @(posedge clk) begin
    if (push.pix_valid) begin
      mem[wr_ptr] <= push.pix;
    end
    if (push.st_valid) begin
      mem[PTR_W'(wr_ptr + PTR_W'(push.pix_valid))] <= push.st;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_n));
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + PTR_W'(1));
      end
      count <= (PTR_W + 1)'(count + (PTR_W + 1)'(push_n) - (PTR_W + 1)'(pop));
    end
  end

  `BMPD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= (PTR_W + 1)'(RES_DEPTH), "result queue overflow")
  `BMPD_ASSERT_IMP(a_double_push_room, clk, rst, push_n == 2'd2, count <= (PTR_W + 1)'(RES_DEPTH - 2), "double push without room")
  `BMPD_ASSERT_NEXT(a_head_held, clk, rst, out_valid && !out_ready, out_valid && $stable(head), "stalled result lost")

endmodule

`default_nettype wire

// ===== hw/rtl/bmpd_core.sv =====
`default_nettype none
`include "bmp_stream_pixel_decoder_top_macros.svh"

module bmpd_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  input  wire logic [bmpd_pkg::SURF_W-1:0] surface_width,
  input  wire logic [bmpd_pkg::SURF_W-1:0] surface_height,
  input  wire logic                        room,
  output bmpd_pkg::core_out_t              res_out
);
  import bmpd_pkg::*;

  // File phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXELS = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Header field offsets and layout.
  localparam logic [5:0] HDR_OFF_DATA   = 6'd10;
  localparam logic [5:0] HDR_OFF_WIDTH  = 6'd18;
  localparam logic [5:0] HDR_OFF_HEIGHT = 6'd22;
  localparam logic [5:0] HDR_OFF_DEPTH  = 6'd28;
  localparam logic [5:0] HDR_LAST       = 6'd53;
  localparam logic [31:0] HDR_BYTES     = 32'd54;
  localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [15:0] DEPTH_32      = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

  // Input register.
  logic       hold_v;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       take;

  // File state.
  logic [2:0]        phase, phase_next;
  logic [31:0]       byte_position, byte_position_next;
  logic [31:0]       data_offset, data_offset_next;
  logic [31:0]       image_width, image_width_next;
  logic [31:0]       image_height, image_height_next;
  logic [15:0]       depth_bits, depth_bits_next;
  logic [15:0]       magic_word, magic_word_next;
  logic [STAT_W-1:0] err_code, err_code_next;
  logic              bottom_up, bottom_up_next;
  logic              wide_pixel, wide_pixel_next;
  logic [DIM_W-1:0]  abs_h, abs_h_next;
  logic [ROW_W-1:0]  data_bytes, data_bytes_next;
  logic [ROW_W-1:0]  padded_bytes, padded_bytes_next;
  logic [DIM_W-1:0]  row_counter, row_counter_next;
  logic [DIM_W-1:0]  y_cur, y_cur_next;
  logic [DIM_W-1:0]  x_cur, x_cur_next;
  logic [ROW_W-1:0]  byte_in_row, byte_in_row_next;
  logic [1:0]        byte_in_pixel, byte_in_pixel_next;
  logic [15:0]       color_acc, color_acc_next;

  logic              pix_hit;
  logic [STAT_W-1:0] st_code;

  assign take     = hold_v && room;
  assign in_ready = !hold_v || take;

  // Input register: a new beat may enter while the held one is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (in_ready) begin
      hold_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  // Per-byte decode: header capture and check, skip, row walk, status.
  always_comb begin
    logic [5:0]       hdr_idx;
    logic [1:0]       lane;
    logic [31:0]      ah32;
    logic             geom_bad;
    logic [DIM_W-1:0] w_dim;
    logic [ROW_W-1:0] dbytes;
    logic             in_data;
    logic             wrap;
    logic             row_end;

    phase_next         = phase;
    byte_position_next = byte_position;
    data_offset_next   = data_offset;
    image_width_next   = image_width;
    image_height_next  = image_height;
    depth_bits_next    = depth_bits;
    magic_word_next    = magic_word;
    err_code_next      = err_code;
    bottom_up_next     = bottom_up;
    wide_pixel_next    = wide_pixel;
    abs_h_next         = abs_h;
    data_bytes_next    = data_bytes;
    padded_bytes_next  = padded_bytes;
    row_counter_next   = row_counter;
    y_cur_next         = y_cur;
    x_cur_next         = x_cur;
    byte_in_row_next   = byte_in_row;
    byte_in_pixel_next = byte_in_pixel;
    color_acc_next     = color_acc;
    pix_hit            = 1'b0;
    st_code            = ST_OK;

    hdr_idx  = byte_position[5:0];
    lane     = 2'b00;
    ah32     = image_height[31] ? 32'(~image_height + 32'd1) : image_height;
    w_dim    = image_width[DIM_W-1:0];
    dbytes   = image_width_next[0] ? '0 : '0;
    geom_bad = 1'b0;
    in_data  = byte_in_row < data_bytes;
    wrap     = 1'b0;
    row_end  = 1'b0;

    if (take) begin
      if (byte_position != '1) begin
        byte_position_next = 32'(byte_position + 32'd1);
      end

      case (phase)
        PH_HEADER: begin
          // Little-endian field capture.
          if (hdr_idx < 6'd2) begin
            magic_word_next[{hdr_idx[0], 3'b000} +: 8] = hold_byte;
          end else if (hdr_idx >= HDR_OFF_DATA && hdr_idx < HDR_OFF_DATA + 6'd4) begin
            lane = 2'(hdr_idx - HDR_OFF_DATA);
            data_offset_next[{lane, 3'b000} +: 8] = hold_byte;
          end else if (hdr_idx >= HDR_OFF_WIDTH && hdr_idx < HDR_OFF_WIDTH + 6'd4) begin
            lane = 2'(hdr_idx - HDR_OFF_WIDTH);
            image_width_next[{lane, 3'b000} +: 8] = hold_byte;
          end else if (hdr_idx >= HDR_OFF_HEIGHT && hdr_idx < HDR_OFF_HEIGHT + 6'd4) begin
            lane = 2'(hdr_idx - HDR_OFF_HEIGHT);
            image_height_next[{lane, 3'b000} +: 8] = hold_byte;
          end else if (hdr_idx >= HDR_OFF_DEPTH && hdr_idx < HDR_OFF_DEPTH + 6'd2) begin
            depth_bits_next[{hdr_idx[0], 3'b000} +: 8] = hold_byte;
          end

          // Header check on its final byte; no checked field lives there.
          if (hdr_idx == HDR_LAST) begin
            geom_bad = (data_offset < HDR_BYTES) || (image_width == '0) ||
                       image_width[31] || (image_width > 32'(MAX_DIM)) ||
                       (ah32 == '0) || (ah32 > 32'(MAX_DIM));
            if (wide_pixel_next == wide_pixel && depth_bits == DEPTH_32) begin
              dbytes = ROW_W'({w_dim, 2'b00});
            end else begin
              dbytes = ROW_W'(ROW_W'({w_dim, 1'b0}) + ROW_W'(w_dim));
            end
            if (magic_word != BMP_MAGIC) begin
              err_code_next = ST_BAD_MAGIC;
              phase_next    = PH_ERROR;
            end else if (depth_bits != DEPTH_24 && depth_bits != DEPTH_32) begin
              err_code_next = ST_BAD_DEPTH;
              phase_next    = PH_ERROR;
            end else if (geom_bad) begin
              err_code_next = ST_BAD_GEOM;
              phase_next    = PH_ERROR;
            end else begin
              wide_pixel_next   = (depth_bits == DEPTH_32);
              bottom_up_next    = !image_height[31];
              abs_h_next        = ah32[DIM_W-1:0];
              data_bytes_next   = dbytes;
              padded_bytes_next = ROW_W'(dbytes + ROW_W'(3)) & ~ROW_W'(3);
              y_cur_next        = image_height[31] ? '0
                                                   : DIM_W'(ah32[DIM_W-1:0] - DIM_W'(1));
              phase_next        = (data_offset == HDR_BYTES) ? PH_PIXELS : PH_SKIP;
            end
          end
        end

        PH_SKIP: begin
          if (33'(byte_position) + 33'd1 >= 33'(data_offset)) begin
            phase_next = PH_PIXELS;
          end
        end

        PH_PIXELS: begin
          // Pixel bytes come in blue, green, red and, for 32 bits, alpha.
          if (in_data) begin
            case (byte_in_pixel)
              2'd0: color_acc_next = {8'h00, hold_byte};
              2'd1: color_acc_next[15:8] = hold_byte;
              2'd2: begin
                pix_hit    = (32'(x_cur) < 32'(surface_width)) &&
                             (32'(y_cur) < 32'(surface_height));
                x_cur_next = DIM_W'(x_cur + DIM_W'(1));
              end
              default: ;
            endcase
            wrap = (byte_in_pixel == 2'd3) || (byte_in_pixel == 2'd2 && !wide_pixel);
            byte_in_pixel_next = wrap ? 2'd0 : 2'(byte_in_pixel + 2'd1);
          end
          byte_in_row_next = ROW_W'(byte_in_row + ROW_W'(1));
          row_end = (byte_in_row_next == padded_bytes);
          if (row_end) begin
            byte_in_row_next   = '0;
            byte_in_pixel_next = '0;
            color_acc_next     = '0;
            x_cur_next         = '0;
            row_counter_next   = DIM_W'(row_counter + DIM_W'(1));
            y_cur_next         = bottom_up ? DIM_W'(y_cur - DIM_W'(1))
                                           : DIM_W'(y_cur + DIM_W'(1));
            if (row_counter_next == abs_h) begin
              phase_next = PH_DONE;
            end
          end
        end

        default: ;
      endcase

      // End of file: report and start the next file from scratch.
      if (hold_last) begin
        case (phase_next)
          PH_HEADER: st_code = ST_SHORT_HDR;
          PH_ERROR:  st_code = err_code_next;
          PH_DONE:   st_code = ST_OK;
          default:   st_code = ST_TRUNCATED;
        endcase
        phase_next         = PH_HEADER;
        byte_position_next = '0;
        data_offset_next   = '0;
        image_width_next   = '0;
        image_height_next  = '0;
        depth_bits_next    = '0;
        magic_word_next    = '0;
        err_code_next      = ST_OK;
        bottom_up_next     = 1'b0;
        wide_pixel_next    = 1'b0;
        abs_h_next         = '0;
        data_bytes_next    = '0;
        padded_bytes_next  = '0;
        row_counter_next   = '0;
        y_cur_next         = '0;
        x_cur_next         = '0;
        byte_in_row_next   = '0;
        byte_in_pixel_next = '0;
        color_acc_next     = '0;
      end
    end
  end

  // Results of this beat, handed to the result queue.
  always_comb begin
    res_out.pix_valid       = take && pix_hit;
    res_out.pix.kind        = KIND_PIXEL;
    res_out.pix.pos_x       = x_cur[POS_W-1:0];
    res_out.pix.pos_y       = y_cur[POS_W-1:0];
    res_out.pix.color       = {ALPHA_OPAQUE, hold_byte, color_acc};
    res_out.pix.status      = ST_OK;
    res_out.pix.last_of_run = !hold_last;

    res_out.st_valid        = take && hold_last;
    res_out.st.kind         = KIND_STATUS;
    res_out.st.pos_x        = '0;
    res_out.st.pos_y        = '0;
    res_out.st.color        = '0;
    res_out.st.status       = st_code;
    res_out.st.last_of_run  = 1'b1;
  end

  // File state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= '0;
      data_offset   <= '0;
      image_width   <= '0;
      image_height  <= '0;
      depth_bits    <= '0;
      magic_word    <= '0;
      err_code      <= ST_OK;
      bottom_up     <= 1'b0;
      wide_pixel    <= 1'b0;
      abs_h         <= '0;
      data_bytes    <= '0;
      padded_bytes  <= '0;
      row_counter   <= '0;
      y_cur         <= '0;
      x_cur         <= '0;
      byte_in_row   <= '0;
      byte_in_pixel <= '0;
      color_acc     <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      data_offset   <= data_offset_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      depth_bits    <= depth_bits_next;
      magic_word    <= magic_word_next;
      err_code      <= err_code_next;
      bottom_up     <= bottom_up_next;
      wide_pixel    <= wide_pixel_next;
      abs_h         <= abs_h_next;
      data_bytes    <= data_bytes_next;
      padded_bytes  <= padded_bytes_next;
      row_counter   <= row_counter_next;
      y_cur         <= y_cur_next;
      x_cur         <= x_cur_next;
      byte_in_row   <= byte_in_row_next;
      byte_in_pixel <= byte_in_pixel_next;
      color_acc     <= color_acc_next;
    end
  end

  `BMPD_ASSERT_IMP(a_last_gives_status, clk, rst, take && hold_last, res_out.st_valid, "last byte without status")
  `BMPD_ASSERT_NEXT(a_last_clears_file, clk, rst, take && hold_last, phase == PH_HEADER && byte_position == '0, "file state not cleared")
  `BMPD_ASSERT_IMP(a_pixel_in_rows, clk, rst, res_out.pix_valid, phase == PH_PIXELS && byte_in_pixel == 2'd2, "pixel write outside row walk")

endmodule

`default_nettype wire

// ===== hw/rtl/bmp_stream_pixel_decoder_top.sv =====
// A byte is held in the input register, then decoded, and its results are registered in the
// result queue before they appear on out_valid.
// Throughput: one byte per cycle while the result queue has room, set by the input register, one
// pass of decode logic and a four-entry queue; a byte's pixel write and status fill two entries.
// Reset: synchronous, active high; clears the file state and the queue and sets the surface
// to 640 by 480.
`default_nettype none

module bmp_stream_pixel_decoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             kind,
  output logic [bmpd_pkg::POS_W-1:0]       pos_x,
  output logic [bmpd_pkg::POS_W-1:0]       pos_y,
  output logic [bmpd_pkg::COLOR_W-1:0]     color,
  output logic [bmpd_pkg::STAT_W-1:0]      status,
  output logic                             last_of_run,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bmpd_pkg::SURF_W-1:0] cfg_data
);
  import bmpd_pkg::*;

  logic [SURF_W-1:0] surface_width;
  logic [SURF_W-1:0] surface_height;
  core_out_t         core_res;
  logic              room;
  res_t              head;

  // Surface size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= SURFACE_WIDTH_RESET;
      surface_height <= SURFACE_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        REG_SURFACE_HEIGHT: surface_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bmpd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .room           (room),
    .res_out        (core_res)
  );

  bmpd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (core_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result beat fields.
  assign kind        = head.kind;
  assign pos_x       = head.pos_x;
  assign pos_y       = head.pos_y;
  assign color       = head.color;
  assign status      = head.status;
  assign last_of_run = head.last_of_run;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bmpd_pkg::*;

  localparam logic [15:0] BMP_MAGIC = 16'h4D42;
  localparam int unsigned HDR_LEN = 54;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned TOTAL_BYTES = 1150;
  localparam int unsigned HOLD_CYCLES = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One BMP file to stream: header fields, total length, and an optional fixed status.
  typedef struct packed {
    logic [15:0] magic;
    logic [15:0] depth;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] len;
    logic        has_st;
    logic [2:0]  st;
  } bmp_file_t;

  typedef enum logic [2:0] {FP_HEADER, FP_SKIP, FP_PIXELS, FP_DONE, FP_ERROR} file_phase_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] data_byte;
  logic last_byte;
  logic out_valid;
  logic out_ready;
  logic kind;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [COLOR_W-1:0] color;
  logic [STAT_W-1:0] status;
  logic last_of_run;
  logic cfg_we;
  logic cfg_index;
  logic [SURF_W-1:0] cfg_data;

  bmp_stream_pixel_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .color(color),
    .status(status),
    .last_of_run(last_of_run),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Directed files: the first bytes after reset, byte extremes, every status code
  // and the check order, then small good images and cut-off large ones.
  bmp_file_t directed_files [0:16] = '{
    '{16'h00FF, 16'd24, 32'd54, 32'd1, 32'd1, 32'd1, 1'b1, ST_SHORT_HDR},
    '{16'h0000, 16'd24, 32'd54, 32'd1, 32'd1, 32'd1, 1'b1, ST_SHORT_HDR},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd2, 32'd2, 32'd53, 1'b1, ST_SHORT_HDR},
    '{16'h424D, 16'd24, 32'd54, 32'd1, 32'd1, 32'd54, 1'b1, ST_BAD_MAGIC},
    '{16'h0000, 16'd16, 32'd53, 32'd0, 32'd0, 32'd54, 1'b1, ST_BAD_MAGIC},
    '{BMP_MAGIC, 16'd16, 32'd53, 32'd0, 32'd0, 32'd54, 1'b1, ST_BAD_DEPTH},
    '{BMP_MAGIC, 16'd24, 32'd53, 32'd1, 32'd1, 32'd54, 1'b1, ST_BAD_GEOM},
    '{BMP_MAGIC, 16'd32, 32'd54, 32'h8000_0000, 32'd1, 32'd54, 1'b1, ST_BAD_GEOM},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd8193, 32'd1, 32'd54, 1'b1, ST_BAD_GEOM},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd1, 32'd0, 32'd54, 1'b1, ST_BAD_GEOM},
    '{BMP_MAGIC, 16'd32, 32'd54, 32'd1, 32'hFFFF_DFFF, 32'd54, 1'b1, ST_BAD_GEOM},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd1, 32'd1, 32'd54, 1'b1, ST_TRUNCATED},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd1, 32'd1, 32'd58, 1'b0, ST_OK},
    '{BMP_MAGIC, 16'd32, 32'd58, 32'd2, 32'hFFFF_FFFE, 32'd77, 1'b0, ST_OK},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd3, 32'd2, 32'd71, 1'b0, ST_OK},
    '{BMP_MAGIC, 16'd24, 32'd54, 32'd8192, 32'd8192, 32'd66, 1'b0, ST_OK},
    '{BMP_MAGIC, 16'd32, 32'h7FFF_FFFF, 32'd8192, 32'hFFFF_E000, 32'd60, 1'b1, ST_TRUNCATED}
  };

  // Surface size and handshake pressure for each phase of the run.
  int unsigned phase_surf_w [NUM_PHASES] = '{640, 3, 8192, 1, 0};
  int unsigned phase_surf_h [NUM_PHASES] = '{480, 2, 8192, 16383, 5};
  int unsigned phase_gap [NUM_PHASES] = '{0, 45, 0, 32, 0};
  int unsigned phase_stall [NUM_PHASES] = '{0, 0, 45, 32, 0};

  // Decoder state as the testbench tracks it.
  file_phase_t fp;
  logic [31:0] byte_pos;
  logic [31:0] pix_offset;
  logic [31:0] img_width;
  logic [31:0] img_height;
  logic [15:0] bits_pp;
  logic [15:0] magic_w;
  logic [31:0] row_len;
  logic [31:0] row_num;
  logic [31:0] row_byte;
  int unsigned pix_byte;
  logic [23:0] bgr_acc;
  logic [2:0] hdr_status;
  int unsigned surf_w;
  int unsigned surf_h;

  res_t step_res[$];
  res_t decoded_beats[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned pixels_seen = 0;
  int unsigned statuses_seen = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles, %0d results still awaited.", cycle_count,
             decoded_beats.size());
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_file();
    fp = FP_HEADER;
    byte_pos = '0;
    pix_offset = '0;
    img_width = '0;
    img_height = '0;
    bits_pp = '0;
    magic_w = '0;
    row_len = '0;
    row_num = '0;
    row_byte = '0;
    pix_byte = 0;
    bgr_acc = '0;
    hdr_status = ST_OK;
  endfunction

  function automatic logic [31:0] height_mag();
    return img_height[31] ? -img_height : img_height;
  endfunction

  // Header checks run when the last header byte arrives; magic, then depth, then geometry.
  function automatic void check_header();
    logic [31:0] ah;
    ah = height_mag();
    if (magic_w != BMP_MAGIC) begin
      hdr_status = ST_BAD_MAGIC;
      fp = FP_ERROR;
    end else if (bits_pp != 16'd24 && bits_pp != 16'd32) begin
      hdr_status = ST_BAD_DEPTH;
      fp = FP_ERROR;
    end else if (pix_offset < HDR_LEN || img_width == 0 || img_width[31] ||
                 img_width > MAX_DIM || ah == 0 || ah > MAX_DIM) begin
      hdr_status = ST_BAD_GEOM;
      fp = FP_ERROR;
    end else begin
      row_len = ((img_width * bits_pp + 31) / 32) * 4;
      fp = (pix_offset == HDR_LEN) ? FP_PIXELS : FP_SKIP;
    end
  endfunction

  // Works out the beats that one file byte causes and leaves them in step_res.
  function automatic void decode_byte(input logic [7:0] b, input logic l);
    logic [31:0] idx;
    logic [31:0] ah;
    logic [31:0] x;
    logic [31:0] y;
    int unsigned bpb;
    res_t r;
    step_res.delete();
    idx = byte_pos;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    case (fp)
      FP_HEADER: begin
        if (idx < 2) magic_w[8*idx +: 8] = b;
        else if (idx >= 10 && idx < 14) pix_offset[8*(idx-10) +: 8] = b;
        else if (idx >= 18 && idx < 22) img_width[8*(idx-18) +: 8] = b;
        else if (idx >= 22 && idx < 26) img_height[8*(idx-22) +: 8] = b;
        else if (idx >= 28 && idx < 30) bits_pp[8*(idx-28) +: 8] = b;
        if (idx == HDR_LEN - 1) check_header();
      end
      FP_SKIP: begin
        if ({1'b0, idx} + 33'd1 >= {1'b0, pix_offset}) fp = FP_PIXELS;
      end
      FP_PIXELS: begin
        bpb = bits_pp / 8;
        ah = height_mag();
        // Bytes come as blue, green, red; the write goes out on red, alpha is dropped.
        if (row_byte < img_width * bpb) begin
          if (pix_byte == 0) bgr_acc = {16'h0, b};
          else if (pix_byte < 3) bgr_acc[8*pix_byte +: 8] = b;
          if (pix_byte == 2) begin
            x = row_byte / bpb;
            y = img_height[31] ? row_num : ah - 1 - row_num;
            if (x < surf_w && y < surf_h) begin
              r = '0;
              r.kind = KIND_PIXEL;
              r.pos_x = x[POS_W-1:0];
              r.pos_y = y[POS_W-1:0];
              r.color = {8'hFF, bgr_acc};
              r.status = ST_OK;
              step_res.push_back(r);
            end
          end
          pix_byte = (pix_byte + 1 >= bpb) ? 0 : pix_byte + 1;
        end
        row_byte++;
        if (row_byte >= row_len) begin
          row_byte = '0;
          pix_byte = 0;
          bgr_acc = '0;
          row_num++;
          if (row_num >= ah) fp = FP_DONE;
        end
      end
      default: ;
    endcase
    if (l) begin
      r = '0;
      r.kind = KIND_STATUS;
      case (fp)
        FP_HEADER: r.status = ST_SHORT_HDR;
        FP_ERROR:  r.status = hdr_status;
        FP_DONE:   r.status = ST_OK;
        default:   r.status = ST_TRUNCATED;
      endcase
      step_res.push_back(r);
      clear_file();
    end
    if (step_res.size() != 0) step_res[step_res.size()-1].last_of_run = 1'b1;
  endfunction

  function automatic int unsigned row_span(int unsigned w, int unsigned d);
    return ((w * d + 31) / 32) * 4;
  endfunction

  // Byte i of a file: header fields where they sit, random filler elsewhere.
  function automatic logic [7:0] file_byte(bmp_file_t f, int unsigned i);
    if (i < 2) return f.magic[8*i +: 8];
    if (i >= 10 && i < 14) return f.offset[8*(i-10) +: 8];
    if (i >= 18 && i < 22) return f.width[8*(i-18) +: 8];
    if (i >= 22 && i < 26) return f.height[8*(i-22) +: 8];
    if (i >= 28 && i < 30) return f.depth[8*(i-28) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed small images; the rest are cut, broken or noise.
  function automatic bmp_file_t random_file();
    bmp_file_t f;
    int unsigned pick;
    int unsigned mag;
    int unsigned nat;
    f.magic = BMP_MAGIC;
    f.depth = $urandom_range(0, 1) ? 16'd32 : 16'd24;
    f.offset = HDR_LEN;
    f.width = 1;
    f.height = 1;
    f.len = HDR_LEN;
    f.has_st = 1'b0;
    f.st = ST_OK;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      f.width = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      mag = $urandom_range(1, 4);
      f.height = $urandom_range(0, 1) ? -mag : mag;
      if ($urandom_range(0, 2) != 0) f.offset = HDR_LEN + $urandom_range(1, 8);
      nat = f.offset + mag * row_span(f.width, f.depth);
      pick = $urandom_range(0, 99);
      if (pick < 65) f.len = nat;
      else if (pick < 80) f.len = nat + $urandom_range(1, 4);
      else f.len = $urandom_range(HDR_LEN, nat - 1);
    end else if (pick < 66) begin
      // Large geometry: only a few pixels arrive before the file ends.
      f.width = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(13, MAX_DIM);
      mag = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(1, MAX_DIM);
      f.height = $urandom_range(0, 1) ? -mag : mag;
      f.offset = HDR_LEN + $urandom_range(0, 2);
      f.len = f.offset + $urandom_range(1, 48);
    end else if (pick < 74) begin
      f.magic = $urandom_range(0, 1) ? BMP_MAGIC : 16'($urandom());
      f.len = $urandom_range(1, HDR_LEN - 1);
    end else if (pick < 80) begin
      do f.magic = 16'($urandom()); while (f.magic == BMP_MAGIC);
      f.depth = 16'($urandom());
      f.offset = $urandom();
      f.width = $urandom();
      f.height = $urandom();
      f.len = HDR_LEN + $urandom_range(0, 6);
    end else if (pick < 86) begin
      do f.depth = 16'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom());
      while (f.depth == 16'd24 || f.depth == 16'd32);
      f.len = HDR_LEN + $urandom_range(0, 6);
    end else if (pick < 94) begin
      case ($urandom_range(0, 5))
        0: f.offset = $urandom_range(0, HDR_LEN - 1);
        1: f.width = 0;
        2: f.width = $urandom() | 32'h8000_0000;
        3: f.width = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
        4: f.height = 0;
        default: begin
          mag = $urandom_range(MAX_DIM + 1, 32'h7FFF_FFFF);
          f.height = $urandom_range(0, 1) ? -mag : mag;
        end
      endcase
      f.len = HDR_LEN + $urandom_range(0, 6);
    end else begin
      // Noise: every header field random.
      f.magic = 16'($urandom());
      f.depth = 16'($urandom());
      f.offset = $urandom();
      f.width = $urandom();
      f.height = $urandom();
      f.len = $urandom_range(1, HDR_LEN + 16);
    end
    return f;
  endfunction

  // Offers one byte at the falling edge and waits for the beat to be taken.
  task automatic send_byte(input logic [7:0] b, input logic l, input bmp_file_t f);
    res_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, l);
    if (!f.has_st) begin
      foreach (step_res[k]) decoded_beats.push_back(step_res[k]);
    end else if (l) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.status = f.st;
      r.last_of_run = 1'b1;
      decoded_beats.push_back(r);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input bmp_file_t f);
    for (int unsigned i = 0; i < f.len; i++) send_byte(file_byte(f, i), i == f.len - 1, f);
    files_sent++;
  endtask

  // Stops offering bytes and lets the decoder empty out.
  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_surface(input int unsigned w, input int unsigned h);
    cfg_we <= 1'b1;
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_data <= w[SURF_W-1:0];
    @(negedge clk);
    cfg_index <= REG_SURFACE_HEIGHT;
    cfg_data <= h[SURF_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    surf_w = w & 32'h3FFF;
    surf_h = h & 32'h3FFF;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare every result beat with the oldest decoded beat.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t ns: beat with nothing awaited, expected none, got kind %0d status %0d",
                   $time, kind, status);
      end else begin
        want = decoded_beats.pop_front();
        check_field("kind", want.kind, kind);
        check_field("pos_x", want.pos_x, pos_x);
        check_field("pos_y", want.pos_y, pos_y);
        check_field("color", want.color, color);
        check_field("status", want.status, status);
        check_field("last_of_run", want.last_of_run, last_of_run);
        if (want.kind == KIND_STATUS) statuses_seen++;
        else pixels_seen++;
      end
    end
  end

  // Stimulus: reset, the directed files, then random files in each phase.
  initial begin
    int unsigned directed_bytes;
    int unsigned phase_goal;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SURFACE_WIDTH;
    cfg_data = '0;
    surf_w = SURFACE_WIDTH_RESET;
    surf_h = SURFACE_HEIGHT_RESET;
    clear_file();
    directed_bytes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        program_surface(phase_surf_w[p], phase_surf_h[p]);
      end
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      if (p == 0) begin
        foreach (directed_files[k]) send_file(directed_files[k]);
        directed_bytes = bytes_sent;
      end
      // Hold the result side off and send a small good image, so the queue fills
      // and the input stalls while bytes keep coming.
      if (p == 2) begin
        hold_req = 1'b1;
        send_file(directed_files[13]);
      end
      // The remaining byte budget is spread evenly over the phases.
      phase_goal = directed_bytes +
                   ((p + 1) * (TOTAL_BYTES - directed_bytes)) / NUM_PHASES;
      do send_file(random_file()); while (bytes_sent < phase_goal);
    end
    drain();

    $display("Streamed %0d bytes in %0d files over %0d surface sizes and four stall patterns.",
             bytes_sent, files_sent, NUM_PHASES);
    $display("Checked %0d pixel writes and %0d end-of-file status beats.",
             pixels_seen, statuses_seen);
    if (mismatches == 0 && decoded_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
